// ===== rtl/isbt_pkg.sv =====
// ----------------------------------------------------------------------------
// isbt_pkg: shared types and constants of the serial bus byte transceiver
// Item layouts, phase codes, request codes and register indexes.
// ----------------------------------------------------------------------------
package isbt_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] elapsed;
    logic        host_clock;
    logic        host_data;
    logic [7:0]  send_byte;
    logic        send_last;
  } in_item_t;

  typedef struct packed {
    logic       drive_clock;
    logic       drive_data;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tx_byte_done;
    logic       tx_finished;
  } out_item_t;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_RTS  = 6'b000010,
    PH_RFD  = 6'b000100,
    PH_EOI  = 6'b001000,
    PH_BITS = 6'b010000,
    PH_ACK  = 6'b100000
  } phase_e;

  localparam logic [1:0] ReqListen = 2'd0;
  localparam logic [1:0] ReqTalk   = 2'd1;
  localparam logic [1:0] ReqTurn   = 2'd2;

  localparam logic [1:0] CfgEoiWait   = 2'd0;
  localparam logic [1:0] CfgStepTime  = 2'd1;
  localparam logic [1:0] CfgTalkDelay = 2'd2;

  localparam logic [15:0] EoiWaitRst   = 16'd160;
  localparam logic [15:0] StepTimeRst  = 16'd200;
  localparam logic [15:0] TalkDelayRst = 16'd220;

  localparam logic [3:0] BitsPerByte = 4'd8;

  // bus levels and timer compares seen by one step
  typedef struct packed {
    logic clk_lvl;
    logic dat_lvl;
    logic gt_eoi;
    logic gt_step;
    logic gt_talk;
  } step_ctx_t;

  typedef struct packed {
    logic       data_we;
    logic       data_nxt;
    logic       timer_clr;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } lsn_res_t;

  typedef struct packed {
    logic clock_we;
    logic clock_nxt;
    logic data_we;
    logic data_nxt;
    logic timer_clr;
    logic done;
    logic fin;
  } tlk_res_t;

endpackage

// ===== rtl/iec_serial_bus_byte_transceiver_core.sv =====
// An accepted item is held in the input stage; its result is registered in the
// output register once that register is free, and leaves from there.
// Throughput: one item per cycle; a held output stalls the single input stage.
// Reset: phases idle, timer and shift state cleared, own lines released,
// registers back to 160 / 200 / 220.
// ----------------------------------------------------------------------------
// iec_serial_bus_byte_transceiver_core: serial bus device byte transceiver
// Input stage, shared saturating timer, listener, talker and result register.
// ----------------------------------------------------------------------------
module iec_serial_bus_byte_transceiver_core #(
  parameter int TIMER_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  isbt_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output isbt_pkg::out_item_t  out_item_o
);

  localparam int SumW = ((TIMER_BITS > 16) ? TIMER_BITS : 16) + 1;
  localparam logic [SumW-1:0] TmrMax = SumW'({TIMER_BITS{1'b1}});

  logic [15:0] eoi_wait_q, step_time_q, talk_delay_q;

  isbt_pkg::in_item_t  in_q;
  logic                in_valid_q;
  isbt_pkg::out_item_t out_q, out_d;
  logic                out_valid_q;

  logic [TIMER_BITS-1:0] timer_q, timer_d, timer_add;
  logic [SumW-1:0]       timer_sum;
  logic                  own_clock_q, own_clock_d, own_data_q, own_data_d;

  logic                  fire, lsn_step, tlk_step;
  isbt_pkg::step_ctx_t   ctx;
  isbt_pkg::lsn_res_t    lsn_res;
  isbt_pkg::tlk_res_t    tlk_res;

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign lsn_step   = fire && (in_q.req_type == isbt_pkg::ReqListen);
  assign tlk_step   = fire && (in_q.req_type == isbt_pkg::ReqTalk);

  assign timer_sum = SumW'(timer_q) + SumW'(in_q.elapsed);
  assign timer_add = (timer_sum > TmrMax) ? {TIMER_BITS{1'b1}}
                                          : timer_sum[TIMER_BITS-1:0];

  assign ctx.clk_lvl = in_q.host_clock | own_clock_q;
  assign ctx.dat_lvl = in_q.host_data | own_data_q;
  assign ctx.gt_eoi  = SumW'(timer_add) > SumW'(eoi_wait_q);
  assign ctx.gt_step = SumW'(timer_add) > SumW'(step_time_q);
  assign ctx.gt_talk = SumW'(timer_add) > SumW'(talk_delay_q);

  isbt_listener u_listener (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (lsn_step),
    .ctx_i  (ctx),
    .res_o  (lsn_res)
  );

  isbt_talker u_talker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (tlk_step),
    .ctx_i       (ctx),
    .send_byte_i (in_q.send_byte),
    .send_last_i (in_q.send_last),
    .res_o       (tlk_res)
  );

  always_comb begin
    timer_d     = timer_add;
    own_clock_d = own_clock_q;
    own_data_d  = own_data_q;
    out_d       = '0;
    unique case (in_q.req_type)
      isbt_pkg::ReqListen: begin
        if (lsn_res.timer_clr) timer_d = '0;
        if (lsn_res.data_we) own_data_d = lsn_res.data_nxt;
        out_d.rx_valid = lsn_res.rx_valid;
        out_d.rx_byte  = lsn_res.rx_byte;
      end
      isbt_pkg::ReqTalk: begin
        if (tlk_res.timer_clr) timer_d = '0;
        if (tlk_res.clock_we) own_clock_d = tlk_res.clock_nxt;
        if (tlk_res.data_we) own_data_d = tlk_res.data_nxt;
        out_d.tx_byte_done = tlk_res.done;
        out_d.tx_finished  = tlk_res.fin;
      end
      isbt_pkg::ReqTurn: begin
        own_clock_d = 1'b1;
        own_data_d  = 1'b0;
      end
      default: begin
      end
    endcase
    out_d.drive_clock = own_clock_d;
    out_d.drive_data  = own_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eoi_wait_q   <= isbt_pkg::EoiWaitRst;
      step_time_q  <= isbt_pkg::StepTimeRst;
      talk_delay_q <= isbt_pkg::TalkDelayRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        isbt_pkg::CfgEoiWait:   eoi_wait_q   <= cfg_data_i;
        isbt_pkg::CfgStepTime:  step_time_q  <= cfg_data_i;
        isbt_pkg::CfgTalkDelay: talk_delay_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      timer_q     <= '0;
      own_clock_q <= 1'b0;
      own_data_q  <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        timer_q     <= timer_d;
        own_clock_q <= own_clock_d;
        own_data_q  <= own_data_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_item_i;
    if (fire) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  a_rx_tx_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.rx_valid && (out_q.tx_byte_done || out_q.tx_finished)))
    else $error("receive and transmit events in one result");

  a_rx_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.rx_valid) |-> (out_q.rx_byte == 8'd0))
    else $error("received byte without rx_valid");

  a_turnaround: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_q.req_type == isbt_pkg::ReqTurn) |=> (own_clock_q && !own_data_q))
    else $error("turnaround did not drive clock and release data");

  a_timer_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(timer_q))
    else $error("timer moved without an item");
`endif

endmodule

// ===== rtl/isbt_listener.sv =====
// ----------------------------------------------------------------------------
// isbt_listener: listener side of the byte handshake
// Ready handshake, end-of-data timeout, bit shifting and frame acknowledge.
// ----------------------------------------------------------------------------
module isbt_listener (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  isbt_pkg::step_ctx_t  ctx_i,
  output isbt_pkg::lsn_res_t   res_o
);

  isbt_pkg::phase_e phase_q, phase_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] cnt_q, cnt_d;
  logic       prev_q, prev_d;
  logic       eoi_q, eoi_d;
  logic [3:0] cnt_inc;

  assign cnt_inc = cnt_q + 4'd1;

  always_comb begin
    phase_d = phase_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    prev_d  = prev_q;
    eoi_d   = eoi_q;
    res_o   = '0;
    unique case (phase_q)
      isbt_pkg::PH_RTS: begin
        if (!ctx_i.clk_lvl) begin
          res_o.data_we   = 1'b1;
          res_o.data_nxt  = 1'b0;
          res_o.timer_clr = 1'b1;
          phase_d         = isbt_pkg::PH_RFD;
          eoi_d           = 1'b0;
        end
      end
      isbt_pkg::PH_RFD: begin
        if (ctx_i.clk_lvl) begin
          phase_d = isbt_pkg::PH_BITS;
          cnt_d   = '0;
          shift_d = '0;
          prev_d  = 1'b1;
        end else if (!eoi_q && ctx_i.gt_eoi) begin
          eoi_d           = 1'b1;
          res_o.data_we   = 1'b1;
          res_o.data_nxt  = 1'b1;
          res_o.timer_clr = 1'b1;
          phase_d         = isbt_pkg::PH_EOI;
        end
      end
      isbt_pkg::PH_EOI: begin
        if (ctx_i.gt_step) begin
          res_o.data_we   = 1'b1;
          res_o.data_nxt  = 1'b0;
          res_o.timer_clr = 1'b1;
          phase_d         = isbt_pkg::PH_RFD;
        end
      end
      isbt_pkg::PH_BITS: begin
        if (prev_q && !ctx_i.clk_lvl) begin
          cnt_d   = cnt_inc;
          shift_d = {~ctx_i.dat_lvl, shift_q[7:1]};
          if (cnt_inc == isbt_pkg::BitsPerByte) begin
            cnt_d           = '0;
            phase_d         = isbt_pkg::PH_ACK;
            res_o.timer_clr = 1'b1;
          end
        end
        prev_d = ctx_i.clk_lvl;
      end
      isbt_pkg::PH_ACK: begin
        if (ctx_i.clk_lvl) begin
          res_o.data_we  = 1'b1;
          res_o.data_nxt = 1'b1;
          if (ctx_i.gt_step) begin
            res_o.timer_clr = 1'b1;
            phase_d         = isbt_pkg::PH_IDLE;
            res_o.rx_valid  = 1'b1;
            res_o.rx_byte   = shift_q;
          end
        end
      end
      default: begin
        phase_d = isbt_pkg::PH_IDLE;
        if (ctx_i.clk_lvl) begin
          res_o.data_we  = 1'b1;
          res_o.data_nxt = 1'b1;
          phase_d        = isbt_pkg::PH_RTS;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= isbt_pkg::PH_IDLE;
      shift_q <= '0;
      cnt_q   <= '0;
      prev_q  <= 1'b0;
      eoi_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      prev_q  <= prev_d;
      eoi_q   <= eoi_d;
    end
  end

endmodule

// ===== rtl/isbt_talker.sv =====
// ----------------------------------------------------------------------------
// isbt_talker: talker side of the byte handshake
// Waits for the listener, end-of-data handshake, bit clocking and frame ack.
// ----------------------------------------------------------------------------
module isbt_talker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  isbt_pkg::step_ctx_t  ctx_i,
  input  logic [7:0]           send_byte_i,
  input  logic                 send_last_i,
  output isbt_pkg::tlk_res_t   res_o
);

  isbt_pkg::phase_e phase_q, phase_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] cnt_q, cnt_d;
  logic       last_q, last_d;
  logic       start_bits;

  always_comb begin
    phase_d    = phase_q;
    shift_d    = shift_q;
    cnt_d      = cnt_q;
    last_d     = last_q;
    start_bits = 1'b0;
    res_o      = '0;
    unique case (phase_q)
      isbt_pkg::PH_RTS: begin
        if (!ctx_i.dat_lvl) phase_d = isbt_pkg::PH_RFD;
      end
      isbt_pkg::PH_RFD: begin
        if (send_last_i) begin
          if (ctx_i.dat_lvl) begin
            phase_d = isbt_pkg::PH_EOI;
            last_d  = 1'b1;
          end
        end else begin
          last_d     = 1'b0;
          start_bits = 1'b1;
        end
      end
      isbt_pkg::PH_EOI: begin
        if (!ctx_i.dat_lvl) start_bits = 1'b1;
      end
      isbt_pkg::PH_BITS: begin
        if (ctx_i.gt_step) begin
          res_o.timer_clr = 1'b1;
          res_o.clock_we  = 1'b1;
          res_o.data_we   = 1'b1;
          if (ctx_i.clk_lvl) begin
            cnt_d           = cnt_q + 4'd1;
            res_o.clock_nxt = 1'b0;
            res_o.data_nxt  = ~shift_q[0];
            shift_d         = {1'b0, shift_q[7:1]};
          end else begin
            res_o.data_nxt  = 1'b0;
            res_o.clock_nxt = 1'b1;
            if (cnt_q == isbt_pkg::BitsPerByte) begin
              cnt_d      = '0;
              phase_d    = isbt_pkg::PH_ACK;
              res_o.done = 1'b1;
            end
          end
        end
      end
      isbt_pkg::PH_ACK: begin
        if (ctx_i.dat_lvl) begin
          if (last_q) begin
            res_o.data_we   = 1'b1;
            res_o.data_nxt  = 1'b1;
            res_o.clock_we  = 1'b1;
            res_o.clock_nxt = 1'b0;
            res_o.fin       = 1'b1;
          end
          phase_d = isbt_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_d = isbt_pkg::PH_IDLE;
        if (ctx_i.dat_lvl && ctx_i.gt_talk) begin
          res_o.clock_we  = 1'b1;
          res_o.clock_nxt = 1'b0;
          res_o.timer_clr = 1'b1;
          phase_d         = isbt_pkg::PH_RTS;
        end
      end
    endcase
    if (start_bits) begin
      res_o.timer_clr = 1'b1;
      res_o.clock_we  = 1'b1;
      res_o.clock_nxt = 1'b1;
      phase_d         = isbt_pkg::PH_BITS;
      shift_d         = send_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= isbt_pkg::PH_IDLE;
      shift_q <= '0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
    end
  end

endmodule
